FILE: rtl/core/owbm_pkg.sv
// Package for the 1-Wire bus master core: transaction structs, operation codes,
// configuration register indexes, reset values and timer defaults.
// No dependencies.
package owbm_pkg;

    localparam int TIMER_WIDTH_DEF   = 10;
    localparam int BITS_PER_TRANSFER = 8;
    localparam int CFG_WIDTH         = 10;
    localparam int CFG_INDEX_WIDTH   = 3;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RESET_LOW  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRES_WAIT  = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RESET_TAIL = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SHORT_LOW  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SLOT       = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RECOVERY   = 3'd5;

    localparam logic [CFG_WIDTH-1:0] RST_RESET_LOW  = 10'd480;
    localparam logic [CFG_WIDTH-1:0] RST_PRES_WAIT  = 10'd80;
    localparam logic [CFG_WIDTH-1:0] RST_RESET_TAIL = 10'd400;
    localparam logic [CFG_WIDTH-1:0] RST_SHORT_LOW  = 10'd1;
    localparam logic [CFG_WIDTH-1:0] RST_SLOT       = 10'd50;
    localparam logic [CFG_WIDTH-1:0] RST_RECOVERY   = 10'd0;

    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_RST_LOW   = 8'b0000_0010,
        PH_RST_WAIT  = 8'b0000_0100,
        PH_RST_TAIL  = 8'b0000_1000,
        PH_SHORT_LOW = 8'b0001_0000,
        PH_RELEASE   = 8'b0010_0000,
        PH_LONG_LOW  = 8'b0100_0000,
        PH_RECOVER   = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        t_op        operation;
        logic [7:0] data_byte;
        logic       line_level;
    } t_in;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_data;
        logic       rejected;
    } t_out;

endpackage

FILE: rtl/core/one_wire_bus_master_core.sv
// 1-Wire bus master core: command/tick sequencer with input and result registers.
// Depends on owbm_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall, payload i_in): each transaction is
//   either a microsecond tick carrying the sampled line level, or a start
//   command (reset with presence detect, byte write, byte read).
//   Output channel (o_out_valid / i_out_stall, payload o_out): one result per
//   input transaction with the open-drain drive to hold until the next one,
//   busy, done, presence, last read byte and a rejected flag.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index; write
//   only while no transaction is in flight.
// Result path: the accepted transaction waits in the input register, and the
// sequencer update is written into the result register when it fires.
// Throughput: one transaction per cycle while the result is not stalled; the
// phase timer and bit shifter state is updated with each transaction.
// Reset: sequencer idle, counters and bytes cleared, registers at defaults,
// both pipeline registers empty.
// Stall: a stalled result holds; the input register keeps one transaction
// and o_in_stall rises while both registers are full and the result is stalled.
module one_wire_bus_master_core #(
    parameter int TIMER_WIDTH = owbm_pkg::TIMER_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  owbm_pkg::t_in                       i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output owbm_pkg::t_out                      o_out,
    input  logic                                i_cfg_we,
    input  logic [owbm_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [owbm_pkg::CFG_WIDTH-1:0]      i_cfg_data
);

    localparam int                   TW       = TIMER_WIDTH;
    localparam int                   CW       = owbm_pkg::CFG_WIDTH;
    localparam int                   DW       = (TW > CW) ? TW : CW;
    localparam logic [TW-1:0]        TMAX     = {TW{1'b1}};
    localparam logic [2:0]           BIT_LAST = 3'(owbm_pkg::BITS_PER_TRANSFER - 1);

    logic [CW-1:0] r_cfg_reset_low, r_cfg_pres_wait, r_cfg_reset_tail;
    logic [CW-1:0] r_cfg_short_low, r_cfg_slot, r_cfg_recovery;

    logic             r_in_valid;
    owbm_pkg::t_in    r_in;
    logic             r_out_valid;
    owbm_pkg::t_out   r_out;

    owbm_pkg::t_phase r_phase, n_phase;
    logic [TW-1:0]    r_tick, n_tick;
    logic [2:0]       r_bit, n_bit;
    logic [7:0]       r_shift, n_shift;
    logic             r_reading, n_reading;
    logic             r_presence, n_presence;
    logic [7:0]       r_received, n_received;

    logic             fire;
    logic [CW-1:0]    dsel;
    logic [DW-1:0]    dsel_ext;
    logic [TW-1:0]    dur;
    logic [TW-1:0]    tick_inc;
    logic             elapsed;
    logic [7:0]       shift_now;
    logic [2:0]       bit_next;
    logic             done;
    logic             rej;
    owbm_pkg::t_phase bit_phase;

    assign fire        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !fire;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_reset_low  <= owbm_pkg::RST_RESET_LOW;
            r_cfg_pres_wait  <= owbm_pkg::RST_PRES_WAIT;
            r_cfg_reset_tail <= owbm_pkg::RST_RESET_TAIL;
            r_cfg_short_low  <= owbm_pkg::RST_SHORT_LOW;
            r_cfg_slot       <= owbm_pkg::RST_SLOT;
            r_cfg_recovery   <= owbm_pkg::RST_RECOVERY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                owbm_pkg::CFG_RESET_LOW:  r_cfg_reset_low  <= i_cfg_data;
                owbm_pkg::CFG_PRES_WAIT:  r_cfg_pres_wait  <= i_cfg_data;
                owbm_pkg::CFG_RESET_TAIL: r_cfg_reset_tail <= i_cfg_data;
                owbm_pkg::CFG_SHORT_LOW:  r_cfg_short_low  <= i_cfg_data;
                owbm_pkg::CFG_SLOT:       r_cfg_slot       <= i_cfg_data;
                owbm_pkg::CFG_RECOVERY:   r_cfg_recovery   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (r_phase)
            owbm_pkg::PH_RST_LOW:   dsel = r_cfg_reset_low;
            owbm_pkg::PH_RST_WAIT:  dsel = r_cfg_pres_wait;
            owbm_pkg::PH_RST_TAIL:  dsel = r_cfg_reset_tail;
            owbm_pkg::PH_SHORT_LOW: dsel = r_cfg_short_low;
            owbm_pkg::PH_RECOVER:   dsel = r_cfg_recovery;
            default:                dsel = r_cfg_slot;
        endcase
    end

    assign dsel_ext = DW'(dsel);
    assign dur      = (dsel_ext > DW'(TMAX)) ? TMAX : TW'(dsel_ext);
    assign tick_inc = (r_tick == TMAX) ? r_tick : r_tick + 1'b1;
    assign elapsed  = (tick_inc >= dur);

    assign shift_now = (r_phase == owbm_pkg::PH_RELEASE && r_reading &&
                        r_tick == '0 && r_in.line_level) ?
                       (r_shift | (8'b1 << r_bit)) : r_shift;
    assign bit_next  = r_bit + 3'd1;
    assign bit_phase = (r_reading || shift_now[bit_next]) ?
                       owbm_pkg::PH_SHORT_LOW : owbm_pkg::PH_LONG_LOW;

    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_reading  = r_reading;
        n_presence = r_presence;
        n_received = r_received;
        done       = 1'b0;
        rej        = 1'b0;
        if (r_in.operation == owbm_pkg::OP_TICK) begin
            if (r_phase != owbm_pkg::PH_IDLE) begin
                n_tick  = elapsed ? '0 : tick_inc;
                n_shift = shift_now;
            end
            unique case (r_phase) inside
                owbm_pkg::PH_IDLE: ;
                owbm_pkg::PH_RST_LOW: begin
                    if (elapsed) n_phase = owbm_pkg::PH_RST_WAIT;
                end
                owbm_pkg::PH_RST_WAIT: begin
                    if (elapsed) begin
                        n_presence = !r_in.line_level;
                        n_phase    = owbm_pkg::PH_RST_TAIL;
                    end
                end
                owbm_pkg::PH_RST_TAIL: begin
                    if (elapsed) begin
                        n_phase = owbm_pkg::PH_IDLE;
                        done    = 1'b1;
                    end
                end
                owbm_pkg::PH_SHORT_LOW: begin
                    if (elapsed) n_phase = owbm_pkg::PH_RELEASE;
                end
                owbm_pkg::PH_LONG_LOW, owbm_pkg::PH_RELEASE, owbm_pkg::PH_RECOVER: begin
                    if (elapsed) begin
                        if (r_phase == owbm_pkg::PH_LONG_LOW && r_cfg_recovery != '0) begin
                            n_phase = owbm_pkg::PH_RECOVER;
                        end else if (r_bit >= BIT_LAST) begin
                            if (r_reading) n_received = shift_now;
                            n_phase = owbm_pkg::PH_IDLE;
                            n_bit   = '0;
                            done    = 1'b1;
                        end else begin
                            n_bit   = bit_next;
                            n_phase = bit_phase;
                        end
                    end
                end
                default: ;
            endcase
        end else if (r_phase != owbm_pkg::PH_IDLE) begin
            rej = 1'b1;
        end else if (r_in.operation == owbm_pkg::OP_RESET) begin
            n_presence = 1'b0;
            n_tick     = '0;
            n_phase    = owbm_pkg::PH_RST_LOW;
        end else begin
            n_reading = (r_in.operation == owbm_pkg::OP_READ);
            n_shift   = n_reading ? 8'd0 : r_in.data_byte;
            n_bit     = '0;
            n_tick    = '0;
            n_phase   = (n_reading || n_shift[0]) ?
                        owbm_pkg::PH_SHORT_LOW : owbm_pkg::PH_LONG_LOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= owbm_pkg::PH_IDLE;
            r_tick      <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_reading   <= 1'b0;
            r_presence  <= 1'b0;
            r_received  <= '0;
        end else begin
            if (!r_in_valid || fire) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (fire) begin
                r_phase    <= n_phase;
                r_tick     <= n_tick;
                r_bit      <= n_bit;
                r_shift    <= n_shift;
                r_reading  <= n_reading;
                r_presence <= n_presence;
                r_received <= n_received;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && (!r_in_valid || fire)) begin
            r_in <= i_in;
        end
        if (fire) begin
            r_out.drive_low <= (n_phase == owbm_pkg::PH_RST_LOW ||
                                n_phase == owbm_pkg::PH_SHORT_LOW ||
                                n_phase == owbm_pkg::PH_LONG_LOW);
            r_out.busy_res  <= (n_phase != owbm_pkg::PH_IDLE);
            r_out.done_res  <= done;
            r_out.presence  <= n_presence;
            r_out.read_data <= n_received;
            r_out.rejected  <= rej;
        end
    end

endmodule
